// ----- design/ftcs_pkg.sv -----
package ftcs_pkg;

   // Field and register widths.
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 7;
   localparam int STEP_W      = 16;
   localparam int SIGMA_W     = 16;
   localparam int IDX_W       = 6;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Grid limits.
   localparam int MAX_POINTS_DEF = 64;
   localparam logic [COUNT_W-1:0] MIN_POINTS = 7'd3;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_POINT_COUNT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_COUNT       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DIFFUSION_NUMBER = 2'd2;

   // Register reset values.
   localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 7'd11;
   localparam logic [STEP_W-1:0]  STEP_COUNT_RST  = 16'd500;
   localparam logic [SIGMA_W-1:0] SIGMA_RST       = 16'd197;

   // Update arithmetic widths: the Laplacian sum is exact in LAP_W bits, the
   // product with sigma in PROD_W bits, the rounded increment in DELTA_W bits.
   localparam int LAP_W   = VALUE_W + 3;
   localparam int PROD_W  = LAP_W + SIGMA_W + 1;
   localparam int DELTA_W = PROD_W - SIGMA_W;
   localparam int SUM_W   = DELTA_W + 1;

   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

// ----- design/ftcs_update.sv -----
module ftcs_update import ftcs_pkg::*; #(
   parameter int AW = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [AW-1:0]      in_index,
   input  value_type          left_value,
   input  value_type          mid_value,
   input  value_type          right_value,
   input  logic [SIGMA_W-1:0] sigma,
   output logic               out_valid,
   output logic [AW-1:0]      out_index,
   output value_type          out_value,
   output logic               active
);

   logic                      v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]             idx1_ff, idx2_ff, idx3_ff;
   value_type                 mid1_ff, mid2_ff, mid3_ff;
   logic signed [LAP_W-1:0]   lap_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [DELTA_W-1:0] delta_ff;
   logic signed [PROD_W-1:0]  rounded;
   logic signed [SUM_W-1:0]   sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage one forms right - 2*mid + left exactly, stage two scales it by
   // sigma, stage three rounds half up back to Q16.16.
   always_ff @(posedge clock) begin
      lap_ff   <= LAP_W'(right_value) - (LAP_W'(mid_value) <<< 1) + LAP_W'(left_value);
      mid1_ff  <= mid_value;
      idx1_ff  <= in_index;
      prod_ff  <= lap_ff * $signed({1'b0, sigma});
      mid2_ff  <= mid1_ff;
      idx2_ff  <= idx1_ff;
      delta_ff <= rounded[PROD_W-1:SIGMA_W];
      mid3_ff  <= mid2_ff;
      idx3_ff  <= idx2_ff;
   end

   assign rounded = prod_ff + PROD_W'(32768);
   assign sum     = SUM_W'(mid3_ff) + SUM_W'(delta_ff);

   always_comb begin
      if (!sum[SUM_W-1] && (|sum[SUM_W-2:VALUE_W-1])) begin
         out_value = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:VALUE_W-1])) begin
         out_value = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         out_value = sum[VALUE_W-1:0];
      end
   end

   assign out_valid = v3_ff;
   assign out_index = idx3_ff;
   assign active    = v1_ff | v2_ff | v3_ff;

endmodule

// ----- design/diffusion_1d_ftcs_solver.sv -----
// One-dimensional explicit heat-equation solver. Pulse start while busy is
// low to load one Q16.16 sample per beat into the next grid point; the load
// that completes the grid (point_count points, clamped to 3..MAX_POINTS)
// raises busy and launches step_count time steps. Each step streams the grid
// out of the field memory, one read per cycle, through the update pipeline
// and writes the new interior values back, then waits for the pipeline to
// empty before the next step. After the last step every point is emitted in
// index order, one beat per cycle on rsp_strobe, with rsp_final_point on the
// last one. The receiver cannot stall these beats and must take each one as
// it appears. The user must write configuration only while busy is low; the
// block itself does not enforce it.
module diffusion_1d_ftcs_solver import ftcs_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   start,
   output logic                   busy,
   input  value_type              req_sample_value,
   output logic                   rsp_strobe,
   output value_type              rsp_result_value,
   output logic [IDX_W-1:0]       rsp_point_index,
   output logic                   rsp_final_point
);

   localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   // Configuration registers.
   logic [COUNT_W-1:0] point_count_ff;
   logic [STEP_W-1:0]  step_count_ff;
   logic [SIGMA_W-1:0] sigma_cfg_ff;

   // Sequencer and run state.
   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [COUNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [STEP_W-1:0]  steps_left_ff, steps_left_in;
   logic [SIGMA_W-1:0] sigma_ff, sigma_in;

   // Read side of the field memory.
   value_type          field_mem [MAX_POINTS];
   value_type          rdata_ff;
   logic               dv_ff;
   logic               ev_ff;
   logic [AW-1:0]      didx_ff;
   value_type          w0_ff, w1_ff;

   logic               accept;
   logic               rd_last;
   logic [COUNT_W-1:0] grid_n;
   logic [COUNT_W-1:0] load_next;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   value_type          wr_data;

   logic               upd_in_valid;
   logic               upd_valid;
   logic [AW-1:0]      upd_index;
   value_type          upd_value;
   logic               upd_active;

   // Configuration writes; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RST;
         step_count_ff  <= STEP_COUNT_RST;
         sigma_cfg_ff   <= SIGMA_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_POINT_COUNT: begin
               point_count_ff <= csr_write_data[COUNT_W-1:0];
            end
            REG_STEP_COUNT: begin
               step_count_ff <= csr_write_data[STEP_W-1:0];
            end
            REG_DIFFUSION_NUMBER: begin
               sigma_cfg_ff <= csr_write_data[SIGMA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Grid size in force, clamped to the supported range.
   always_comb begin
      if (point_count_ff < MIN_POINTS) begin
         grid_n = MIN_POINTS;
      end else if (point_count_ff > COUNT_W'(MAX_POINTS)) begin
         grid_n = COUNT_W'(MAX_POINTS);
      end else begin
         grid_n = point_count_ff;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign load_next = load_cnt_ff + COUNT_W'(1);
   assign rd_last   = (COUNT_W'(rd_cnt_ff) == n_ff - COUNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      load_cnt_in   = load_cnt_ff;
      n_in          = n_ff;
      steps_left_in = steps_left_ff;
      sigma_in      = sigma_ff;
      case (state_ff)
         ST_IDLE: begin
            // The load that reaches the grid size launches the run with
            // the registers latched as they stand.
            if (accept) begin
               if (load_next >= grid_n) begin
                  load_cnt_in   = '0;
                  n_in          = grid_n;
                  sigma_in      = sigma_cfg_ff;
                  steps_left_in = step_count_ff;
                  state_in      = (step_count_ff == '0) ? ST_EMIT : ST_SWEEP;
               end else begin
                  load_cnt_in = load_next;
               end
            end
         end
         ST_SWEEP: begin
            rd_cnt_in = rd_cnt_ff + AW'(1);
            if (rd_last) begin
               rd_cnt_in = '0;
               state_in  = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The next step may read any point written in this one, so it
            // starts only once every write-back has landed.
            if (!dv_ff && !upd_active) begin
               steps_left_in = steps_left_ff - STEP_W'(1);
               state_in      = (steps_left_ff == STEP_W'(1)) ? ST_EMIT : ST_SWEEP;
            end
         end
         ST_EMIT: begin
            rd_cnt_in = rd_cnt_ff + AW'(1);
            if (rd_last) begin
               rd_cnt_in = '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_cnt_ff     <= '0;
         load_cnt_ff   <= '0;
         n_ff          <= MIN_POINTS;
         steps_left_ff <= '0;
         sigma_ff      <= '0;
         dv_ff         <= 1'b0;
         ev_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_cnt_ff     <= rd_cnt_in;
         load_cnt_ff   <= load_cnt_in;
         n_ff          <= n_in;
         steps_left_ff <= steps_left_in;
         sigma_ff      <= sigma_in;
         dv_ff         <= (state_ff == ST_SWEEP);
         ev_ff         <= (state_ff == ST_EMIT);
      end
   end

   // Loads and write-backs share the single write port; they never coincide
   // because loads are taken only while the sequencer is idle.
   assign wr_en   = accept || upd_valid;
   assign wr_addr = accept ? load_cnt_ff[AW-1:0] : upd_index;
   assign wr_data = accept ? req_sample_value : upd_value;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         field_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= field_mem[rd_cnt_ff];
   end

   // The two older values of the sweep sit in a small window, so each point
   // is read from memory once per step.
   always_ff @(posedge clock) begin
      didx_ff <= rd_cnt_ff;
      if (dv_ff) begin
         w0_ff <= w1_ff;
         w1_ff <= rdata_ff;
      end
   end

   assign upd_in_valid = dv_ff && (didx_ff >= AW'(2));

   ftcs_update #(
      .AW (AW)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (upd_in_valid),
      .in_index    (didx_ff - AW'(1)),
      .left_value  (w0_ff),
      .mid_value   (w1_ff),
      .right_value (rdata_ff),
      .sigma       (sigma_ff),
      .out_valid   (upd_valid),
      .out_index   (upd_index),
      .out_value   (upd_value),
      .active      (upd_active)
   );

   // Results come straight from the registered memory read.
   assign rsp_strobe       = ev_ff;
   assign rsp_result_value = rdata_ff;
   assign rsp_point_index  = IDX_W'(didx_ff);
   assign rsp_final_point  = ev_ff && (COUNT_W'(didx_ff) == n_ff - COUNT_W'(1));

endmodule
